// ----- hw/rtl/bmg_pkg.sv -----
// Shared types, constants and arithmetic helpers for the Box-Muller gaussian generator.
// Used by bmg_front, bmg_queue, bmg_back and the top level; depends on nothing.
`default_nettype none

package bmg_pkg;

    localparam int UNIFORM_WIDTH = 32;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRAC_OUT      = SAMPLE_WIDTH - 5;
    localparam int LOG_BITS      = 28;
    localparam int CORDIC_STEPS  = 28;
    localparam int ROOT_BITS     = 31;
    localparam int RAD_BITS      = 2 * ROOT_BITS;
    localparam int CNT_W         = 5;

    localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
    localparam logic [29:0] GAIN_Q30    = 30'd652032874;

    localparam logic signed [34:0] ROUND_HALF = 35'sd1 <<< (27 - FRAC_OUT);
    localparam logic signed [34:0] SAMPLE_MAX = (35'sd1 <<< (SAMPLE_WIDTH - 1)) - 35'sd1;
    localparam logic signed [34:0] SAMPLE_MIN = -SAMPLE_MAX - 35'sd1;

    typedef struct packed {
        logic [UNIFORM_WIDTH-1:0] uniform_mag;
        logic [UNIFORM_WIDTH-1:0] uniform_phase;
    } bmg_req_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           from_cache;
    } bmg_rsp_t;

    typedef struct packed {
        logic     cached;
        bmg_req_t req;
    } bmg_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_SCALE,
        ST_SQRT,
        ST_GAIN,
        ST_ROTATE,
        ST_FINISH,
        ST_OUT
    } bmg_state_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [CNT_W-1:0] i);
        logic [29:0] a;
        case (i)
            5'd0:    a = 30'd536870912;
            5'd1:    a = 30'd316933406;
            5'd2:    a = 30'd167458907;
            5'd3:    a = 30'd85004756;
            5'd4:    a = 30'd42667331;
            5'd5:    a = 30'd21354465;
            5'd6:    a = 30'd10679838;
            5'd7:    a = 30'd5340245;
            5'd8:    a = 30'd2670163;
            5'd9:    a = 30'd1335087;
            5'd10:   a = 30'd667544;
            5'd11:   a = 30'd333772;
            5'd12:   a = 30'd166886;
            5'd13:   a = 30'd83443;
            5'd14:   a = 30'd41722;
            5'd15:   a = 30'd20861;
            5'd16:   a = 30'd10430;
            5'd17:   a = 30'd5215;
            5'd18:   a = 30'd2608;
            5'd19:   a = 30'd1304;
            5'd20:   a = 30'd652;
            5'd21:   a = 30'd326;
            5'd22:   a = 30'd163;
            5'd23:   a = 30'd81;
            5'd24:   a = 30'd41;
            5'd25:   a = 30'd20;
            5'd26:   a = 30'd10;
            5'd27:   a = 30'd5;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

    // Q.28 to output format: round half up, then saturate
    function automatic logic signed [SAMPLE_WIDTH-1:0] to_output(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [34:0] r;
        logic signed [34:0] c;
        t = $signed({v[33], v}) + ROUND_HALF;
        r = t >>> (28 - FRAC_OUT);
        if (r > SAMPLE_MAX) begin
            c = SAMPLE_MAX;
        end
        else if (r < SAMPLE_MIN) begin
            c = SAMPLE_MIN;
        end
        else begin
            c = r;
        end
        return c[SAMPLE_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bmg_front.sv -----
// Request front end: takes request words and tags each as a cached or a fresh job.
// Depends on bmg_pkg.
`default_nettype none

module bmg_front
    import bmg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire bmg_req_t req,
    output logic          push_valid,
    input  wire logic     push_ready,
    output bmg_job_t      push_job
);

    logic pending_reg;
    logic pending_next;

    assign req_ready       = push_ready;
    assign push_valid      = req_valid;
    assign push_job.cached = pending_reg;
    assign push_job.req    = req;

    // every fresh pair leaves a cosine half behind for the following word
    always_comb
    begin
        pending_next = pending_reg;
        if (req_valid && push_ready)
        begin
            pending_next = ~pending_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bmg_queue.sv -----
// Short job queue between front end and compute back end.
// Depends on bmg_pkg.
`default_nettype none

module bmg_queue
    import bmg_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire bmg_job_t push_job,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output bmg_job_t      pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    bmg_job_t          mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_QW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bmg_back.sv -----
// Compute back end: log by repeated squaring, bit-serial square root, CORDIC rotation,
// and the one-entry sample cache. Depends on bmg_pkg.
`default_nettype none

module bmg_back
    import bmg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_valid,
    output logic          job_ready,
    input  wire bmg_job_t job,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output bmg_rsp_t      rsp
);

    localparam logic signed [33:0] QUARTER = 34'sd1 <<< 30;
    localparam logic signed [33:0] HALF    = 34'sd1 <<< 31;

    bmg_state_t                     state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [30:0]                    m_reg, m_next;
    logic [LOG_BITS-1:0]            lf_reg, lf_next;
    logic [CNT_W-1:0]               p_reg, p_next;
    logic [RAD_BITS-1:0]            rad_reg, rad_next;
    logic [32:0]                    rem_reg, rem_next;
    logic [ROOT_BITS-1:0]           root_reg, root_next;
    logic signed [33:0]             x_reg, x_next;
    logic signed [33:0]             y_reg, y_next;
    logic signed [33:0]             z_reg, z_next;
    logic                           flip_reg, flip_next;
    logic signed [SAMPLE_WIDTH-1:0] cached_sample_reg, cached_sample_next;
    bmg_rsp_t                       rsp_reg, rsp_next;
    logic                           rsp_valid_reg, rsp_valid_next;

    logic [UNIFORM_WIDTH-1:0] u1;
    logic [31:0]              u32;
    logic [31:0]              u_shift;
    logic [CNT_W-1:0]         lead;
    logic [30:0]              m_norm;
    logic [31:0]              ph32;
    logic signed [33:0]       z_init;
    logic                     flip_init;
    logic [61:0]              sq;
    logic [31:0]              sq_top;
    logic [5:0]               int_part;
    logic [33:0]              nl;
    logic [62:0]              nl_prod;
    logic [34:0]              rem_sh;
    logic [34:0]              trial;
    logic [60:0]              gain_prod;
    logic signed [33:0]       dx, dy, at;
    logic signed [33:0]       xf, yf;

    assign job_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // datapath pieces shared by the state machine
    always_comb
    begin
        u1 = (job.req.uniform_mag == '0) ? UNIFORM_WIDTH'(1) : job.req.uniform_mag;
        u32 = 32'(u1);
        lead = '0;
        for (int i = 0; i < UNIFORM_WIDTH; i++)
        begin
            if (u1[i])
            begin
                lead = CNT_W'(i);
            end
        end
        u_shift = u32 << (5'd30 - lead);
        m_norm = (lead == 5'd31) ? u32[31:1] : u_shift[30:0];

        ph32 = 32'(job.req.uniform_phase) << (32 - UNIFORM_WIDTH);
        z_init = $signed({{2{ph32[31]}}, ph32});
        flip_init = 1'b0;
        if (z_init > QUARTER)
        begin
            z_init = z_init - HALF;
            flip_init = 1'b1;
        end
        else if (z_init < -QUARTER)
        begin
            z_init = z_init + HALF;
            flip_init = 1'b1;
        end

        sq = m_reg * m_reg;
        sq_top = sq[61:30];

        int_part = 6'(UNIFORM_WIDTH) - {1'b0, p_reg};
        nl = {int_part, {LOG_BITS{1'b0}}} - {6'b0, lf_reg};
        nl_prod = nl * TWO_LN2_Q28;

        rem_sh = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};

        gain_prod = root_reg * GAIN_Q30;

        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        at = $signed({4'b0, atan_turn(cnt_reg)});

        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
    end

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        m_next             = m_reg;
        lf_next            = lf_reg;
        p_next             = p_reg;
        rad_next           = rad_reg;
        rem_next           = rem_reg;
        root_next          = root_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        z_next             = z_reg;
        flip_next          = flip_reg;
        cached_sample_next = cached_sample_reg;
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.cached)
                    begin
                        rsp_next.sample     = cached_sample_reg;
                        rsp_next.from_cache = 1'b1;
                        rsp_valid_next      = 1'b1;
                        state_next          = ST_OUT;
                    end
                    else
                    begin
                        m_next     = m_norm;
                        p_next     = lead;
                        lf_next    = '0;
                        z_next     = z_init;
                        flip_next  = flip_init;
                        cnt_next   = '0;
                        state_next = ST_LOG;
                    end
                end
            end
            ST_LOG:
            begin
                // square and renormalise; a carry into bit 31 is a one in the log
                if (sq_top[31])
                begin
                    m_next  = sq_top[31:1];
                    lf_next = {lf_reg[LOG_BITS-2:0], 1'b1};
                end
                else
                begin
                    m_next  = sq_top[30:0];
                    lf_next = {lf_reg[LOG_BITS-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(LOG_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCALE:
            begin
                rad_next   = {nl_prod[61:28], {LOG_BITS{1'b0}}};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = 33'(rem_sh - trial);
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = 33'(rem_sh);
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                rad_next = {rad_reg[RAD_BITS-3:0], 2'b00};
                if (cnt_reg == CNT_W'(ROOT_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_GAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_GAIN:
            begin
                x_next     = $signed({3'b000, gain_prod[60:30]});
                y_next     = '0;
                cnt_next   = '0;
                state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                rsp_next.sample     = to_output(yf);
                rsp_next.from_cache = 1'b0;
                cached_sample_next  = to_output(xf);
                rsp_valid_next      = 1'b1;
                state_next          = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_ready)
                begin
                    rsp_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            rsp_valid_reg     <= 1'b0;
            cached_sample_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            rsp_valid_reg     <= rsp_valid_next;
            cached_sample_reg <= cached_sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        lf_reg   <= lf_next;
        p_reg    <= p_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/box_muller_gaussian.sv -----
// Box-Muller gaussian generator: a fresh request of two uniforms yields the sine half
// in Q4.11 and keeps the cosine half, which answers the next request (from_cache set).
// A fresh word, once it leaves the queue, is worked through 28 log squarings,
// 31 square-root digit steps and 28 CORDIC rotations on one shared datapath, plus
// setup, scaling, gain and rounding steps. A cached word answers in the cycle after it
// leaves the queue. A queue of QUEUE_DEPTH words lets requests be taken while the
// back end is busy or its result waits on rsp_ready.
// Depends on bmg_pkg, bmg_front, bmg_queue and bmg_back.
`default_nettype none

module box_muller_gaussian
    import bmg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire bmg_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output bmg_rsp_t      rsp
);

    logic     push_valid;
    logic     push_ready;
    bmg_job_t push_job;
    logic     job_valid;
    logic     job_ready;
    bmg_job_t job;

    bmg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    bmg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_job    (job)
    );

    bmg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef NO_ASSERTIONS
    // an accepted word must be waiting in the queue at the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> job_valid)
        else $error("accepted request not visible in queue");

    // after a hand-over the back end returns to idle, so rsp_valid is low in the cycle after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) |=> !rsp_valid)
        else $error("result raised again straight after hand-over");
`endif

endmodule

`default_nettype wire
